// ===== rtl/core/sva_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sva_pkg
// Shared command codes, status codes, register indexes and word types of the
// voice allocator.
// ----------------------------------------------------------------------------
package sva_pkg;

    localparam logic [2:0] CMD_NOTE_ON     = 3'd0;
    localparam logic [2:0] CMD_NOTE_OFF    = 3'd1;
    localparam logic [2:0] CMD_RELEASE_ALL = 3'd2;
    localparam logic [2:0] CMD_TICK        = 3'd3;
    localparam logic [2:0] CMD_QUERY       = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [3:0] CFG_POLYPHONY     = 4'd0;
    localparam logic [3:0] CFG_RELEASE_TICKS = 4'd1;

    localparam logic [4:0]  POLYPHONY_RESET     = 5'd8;
    localparam logic [15:0] RELEASE_TICKS_RESET = 16'd4800;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [6:0]  note_id;
        logic [7:0]  velocity;
        logic [15:0] tick_count;
        logic [3:0]  slot;
    } t_sva_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  assigned_slot;
        logic [4:0]  released_count;
        logic [4:0]  freed_count;
        logic [4:0]  active_count;
        logic        q_valid;
        logic [6:0]  q_note;
        logic [7:0]  q_velocity;
        logic        q_held;
        logic [31:0] q_pressed_time;
    } t_sva_out;

endpackage
`default_nettype wire

// ===== rtl/core/synth_voice_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// synth_voice_allocator
// Voice table of a polyphonic synth with oldest-voice stealing.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_in and raise start; the word is taken at the
//   clock edge where start is high and busy is low. busy stays high until
//   the result word has been shown.
//   Result channel: o_out carries one word per command, valid for exactly the
//   single cycle in which o_done is high. The receiver cannot stall it.
//   Configuration: i_cfg_index / i_cfg_data, taken when i_cfg_valid is high
//   (o_cfg_ready is always high). Write only while busy is low.
// Scans: release-all, note-off, tick and note-on step through the voice
//   table slot by slot; note-on steps through it once more for every
//   stolen voice. The slot scan reads one voice-table entry per cycle from
//   the single-read-port memory. The next command can be taken in the cycle
//   after the result word.
// Reset: synchronous, active low. Clears time, valid and held bits, the
//   held count and the registers to 8 voices and 4800 ticks. The table
//   payload is not cleared: it is always written before it is read.
// ----------------------------------------------------------------------------
module synth_voice_allocator
    import sva_pkg::*;
#(
    parameter int MAX_VOICES = 16,
    parameter int TIME_BITS  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_sva_in     i_in,
    output logic             o_done,
    output t_sva_out         o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CW = $clog2(MAX_VOICES + 1);
    localparam int LW = (CW > 5) ? CW : 5;
    localparam int SW = (VW > 4) ? VW : 4;
    localparam int PW = (TIME_BITS > 32) ? TIME_BITS : 32;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MATCH  = 9'b000000010,
        S_CHK    = 9'b000000100,
        S_STEAL  = 9'b000001000,
        S_ALLOC  = 9'b000010000,
        S_RELALL = 9'b000100000,
        S_TICK   = 9'b001000000,
        S_QUERY  = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state;

    // configuration
    logic [4:0]  r_poly;
    logic [15:0] r_rel_ticks;

    // control state
    logic [TIME_BITS-1:0] r_time;
    logic [MAX_VOICES-1:0] r_valid;
    logic [MAX_VOICES-1:0] r_held;
    logic [CW-1:0] r_held_cnt;

    // latched command
    logic [2:0] r_cmd;
    logic [6:0] r_note;
    logic [7:0] r_vel;
    logic       r_q_in;

    // scan control
    logic [VW:0]   r_idx;
    logic          r_ev;
    logic [VW-1:0] r_ev_idx;
    logic          r_best_vld;
    logic [VW-1:0] r_best_idx;
    logic [TIME_BITS-1:0] r_best_p;

    // result registers
    logic [1:0]    r_status;
    logic [VW-1:0] r_slot;
    logic [CW-1:0] r_released;
    logic [CW-1:0] r_freed;
    logic          r_qv;
    logic [6:0]    r_qn;
    logic [7:0]    r_qvel;
    logic          r_qh;
    logic [TIME_BITS-1:0] r_qp;

    // voice table: note, velocity, press time, release length written on
    // note-on; release start written on release
    logic [6:0]           mem_note  [MAX_VOICES];
    logic [7:0]           mem_vel   [MAX_VOICES];
    logic [TIME_BITS-1:0] mem_press [MAX_VOICES];
    logic [15:0]          mem_len   [MAX_VOICES];
    logic [TIME_BITS-1:0] mem_rel   [MAX_VOICES];

    logic [6:0]           r_rd_note;
    logic [7:0]           r_rd_vel;
    logic [TIME_BITS-1:0] r_rd_press;
    logic [15:0]          r_rd_len;
    logic [TIME_BITS-1:0] r_rd_rel;

    logic [VW-1:0] rd_addr;
    logic          we_a;
    logic [VW-1:0] wa_addr;
    logic          we_b;
    logic [VW-1:0] wb_addr;

    logic [SW-1:0] slot_x;
    logic          accept;
    logic          scan_end;
    logic [LW-1:0] lim;
    logic [LW-1:0] held_x;
    logic          free_vld;
    logic [VW-1:0] free_idx;
    logic [TIME_BITS-1:0] gone;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign slot_x      = SW'(i_in.slot);
    assign scan_end    = (r_idx == (VW+1)'(MAX_VOICES)) && !r_ev;
    assign held_x      = LW'(r_held_cnt);
    assign gone        = r_time - r_rd_rel;

    // polyphony 0 acts as 1, above the table size as the table size
    always_comb begin
        if (r_poly == 5'd0) begin
            lim = LW'(1);
        end else if (LW'(r_poly) > LW'(MAX_VOICES)) begin
            lim = LW'(MAX_VOICES);
        end else begin
            lim = LW'(r_poly);
        end
    end

    // lowest free slot
    always_comb begin
        free_vld = 1'b0;
        free_idx = '0;
        for (int v = MAX_VOICES - 1; v >= 0; v--) begin
            if (!r_valid[v]) begin
                free_vld = 1'b1;
                free_idx = VW'(v);
            end
        end
    end

    always_comb begin
        if (r_state == S_IDLE) begin
            rd_addr = slot_x[VW-1:0];
        end else begin
            rd_addr = r_idx[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_note  <= mem_note[rd_addr];
        r_rd_vel   <= mem_vel[rd_addr];
        r_rd_press <= mem_press[rd_addr];
        r_rd_len   <= mem_len[rd_addr];
        r_rd_rel   <= mem_rel[rd_addr];
        if (we_a) begin
            mem_note[wa_addr]  <= r_note;
            mem_vel[wa_addr]   <= r_vel;
            mem_press[wa_addr] <= r_time;
            mem_len[wa_addr]   <= r_rel_ticks;
        end
        if (we_b) begin
            mem_rel[wb_addr] <= r_time;
        end
    end

    // memory write strobes
    always_comb begin
        we_a    = 1'b0;
        wa_addr = free_idx;
        we_b    = 1'b0;
        wb_addr = r_ev_idx;
        unique case (r_state)
            S_ALLOC: begin
                we_a = free_vld;
            end
            S_MATCH: begin
                we_b = r_ev && r_valid[r_ev_idx] && r_held[r_ev_idx]
                       && (r_rd_note == r_note);
            end
            S_STEAL: begin
                we_b    = scan_end;
                wb_addr = r_best_idx;
            end
            S_RELALL: begin
                wb_addr = r_idx[VW-1:0];
                we_b    = (r_idx != (VW+1)'(MAX_VOICES))
                          && r_valid[r_idx[VW-1:0]] && r_held[r_idx[VW-1:0]];
            end
            default: begin
                we_b = 1'b0;
            end
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly      <= POLYPHONY_RESET;
            r_rel_ticks <= RELEASE_TICKS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POLYPHONY:     r_poly      <= i_cfg_data[4:0];
                CFG_RELEASE_TICKS: r_rel_ticks <= i_cfg_data;
                default:           r_poly      <= r_poly;
            endcase
        end
    end

    // command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_time     <= '0;
            r_valid    <= '0;
            r_held     <= '0;
            r_held_cnt <= '0;
            r_idx      <= '0;
            r_ev       <= 1'b0;
        end else begin
            // advance the scan pipeline: address now, evaluate next cycle
            if (r_idx != (VW+1)'(MAX_VOICES)) begin
                r_idx <= r_idx + 1'b1;
            end
            r_ev     <= (r_idx != (VW+1)'(MAX_VOICES));
            r_ev_idx <= r_idx[VW-1:0];

            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    r_ev  <= 1'b0;
                    if (accept) begin
                        r_cmd      <= i_in.cmd;
                        r_note     <= i_in.note_id;
                        r_vel      <= i_in.velocity;
                        r_q_in     <= ((SW+1)'(slot_x) < (SW+1)'(MAX_VOICES));
                        r_status   <= STATUS_OK;
                        r_slot     <= '0;
                        r_released <= '0;
                        r_freed    <= '0;
                        r_qv       <= 1'b0;
                        r_qn       <= '0;
                        r_qvel     <= '0;
                        r_qh       <= 1'b0;
                        r_qp       <= '0;
                        r_best_vld <= 1'b0;
                        case (i_in.cmd)
                            CMD_NOTE_ON, CMD_NOTE_OFF: r_state <= S_MATCH;
                            CMD_RELEASE_ALL:           r_state <= S_RELALL;
                            CMD_TICK: begin
                                r_time  <= r_time + TIME_BITS'(i_in.tick_count);
                                r_state <= S_TICK;
                            end
                            CMD_QUERY:                 r_state <= S_QUERY;
                            default:                   r_state <= S_DONE;
                        endcase
                    end
                end
                S_MATCH: begin
                    // release the first held voice with the same note
                    if (we_b) begin
                        r_held[r_ev_idx] <= 1'b0;
                        r_held_cnt       <= r_held_cnt - 1'b1;
                        r_released       <= CW'(1);
                        r_state          <= (r_cmd == CMD_NOTE_ON) ? S_CHK : S_DONE;
                    end else if (scan_end) begin
                        if (r_cmd == CMD_NOTE_ON) begin
                            r_state <= S_CHK;
                        end else begin
                            r_status <= STATUS_NOT_FOUND;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_CHK: begin
                    // steal while the held count is at or above the limit
                    r_idx      <= '0;
                    r_ev       <= 1'b0;
                    r_best_vld <= 1'b0;
                    if (held_x >= lim && r_held_cnt != '0) begin
                        r_state <= S_STEAL;
                    end else begin
                        r_state <= S_ALLOC;
                    end
                end
                S_STEAL: begin
                    if (r_ev && r_valid[r_ev_idx] && r_held[r_ev_idx]
                        && (!r_best_vld || r_rd_press < r_best_p)) begin
                        r_best_vld <= 1'b1;
                        r_best_idx <= r_ev_idx;
                        r_best_p   <= r_rd_press;
                    end
                    if (scan_end) begin
                        r_held[r_best_idx] <= 1'b0;
                        r_held_cnt         <= r_held_cnt - 1'b1;
                        r_released         <= r_released + 1'b1;
                        r_state            <= S_CHK;
                    end
                end
                S_ALLOC: begin
                    if (free_vld) begin
                        r_valid[free_idx] <= 1'b1;
                        r_held[free_idx]  <= 1'b1;
                        r_held_cnt        <= r_held_cnt + 1'b1;
                        r_slot            <= free_idx;
                    end else begin
                        r_status <= STATUS_FULL;
                    end
                    r_state <= S_DONE;
                end
                S_RELALL: begin
                    if (we_b) begin
                        r_held[r_idx[VW-1:0]] <= 1'b0;
                        r_held_cnt            <= r_held_cnt - 1'b1;
                        r_released            <= r_released + 1'b1;
                    end
                    if (r_idx == (VW+1)'(MAX_VOICES)) begin
                        r_state <= S_DONE;
                    end
                end
                S_TICK: begin
                    // free voices whose release has run its length
                    if (r_ev && r_valid[r_ev_idx] && !r_held[r_ev_idx]
                        && gone >= TIME_BITS'(r_rd_len)) begin
                        r_valid[r_ev_idx] <= 1'b0;
                        r_freed           <= r_freed + 1'b1;
                    end
                    if (scan_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_QUERY: begin
                    if (r_q_in && r_valid[r_idx[VW-1:0]]) begin
                        r_qv   <= 1'b1;
                        r_qn   <= r_rd_note;
                        r_qvel <= r_rd_vel;
                        r_qh   <= r_held[r_idx[VW-1:0]];
                        r_qp   <= r_rd_press;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // hold the query slot address while its data is read
            if (r_state == S_IDLE && accept && i_in.cmd == CMD_QUERY) begin
                r_idx <= (VW+1)'(slot_x[VW-1:0]);
            end
        end
    end

    logic [LW-1:0] rel_x;
    logic [LW-1:0] freed_x;
    logic [SW-1:0] slot_o;
    logic [PW-1:0] qp_x;

    assign rel_x   = LW'(r_released);
    assign freed_x = LW'(r_freed);
    assign slot_o  = SW'(r_slot);
    assign qp_x    = PW'(r_qp);

    assign o_done = (r_state == S_DONE);

    always_comb begin
        o_out                = '0;
        o_out.status         = r_status;
        o_out.assigned_slot  = slot_o[3:0];
        o_out.released_count = rel_x[4:0];
        o_out.freed_count    = freed_x[4:0];
        o_out.active_count   = held_x[4:0];
        o_out.q_valid        = r_qv;
        o_out.q_note         = r_qn;
        o_out.q_velocity     = r_qvel;
        o_out.q_held         = r_qh;
        o_out.q_pressed_time = qp_x[31:0];
    end

endmodule
`default_nettype wire
